// ===== sv/cvc_pkg.sv =====
// ---------------------------------------------------------------------------
// cvc_pkg: shared definitions for the collinear vertex culler
// Coordinate width, multiply digit size, register map, phase codes and the
// sequencer encodings.
// ---------------------------------------------------------------------------
`default_nettype none

package cvc_pkg;

	// Default coordinate width in bits (Q16.16).
	localparam int CVC_COORD_BITS = 32;

	// Stream payload width: two 32-bit coordinates.
	localparam int CVC_DATA_W = 64;
	localparam int CVC_FIELD_W = 32;

	// Configuration port.
	localparam int CVC_PADDR_W = 3;
	localparam int CVC_PDATA_W = 32;
	localparam logic CFG_IDX_COS_THR = 1'b0;

	// Cosine threshold, Q1.15, reset value is 0.76.
	localparam int CVC_THR_W = 16;
	localparam logic [CVC_THR_W-1:0] CVC_THR_RESET = 16'd24904;

	// The squared dot product is scaled by 2^30 (the square of Q1.15 one).
	localparam int CVC_LHS_SHIFT = 30;

	// Bits of the multiplier consumed per step of the shared multiplier.
	localparam int MUL_DIGIT = 8;

	// Polygon phase codes.
	localparam logic [1:0] PH_NONE  = 2'd0;
	localparam logic [1:0] PH_FIRST = 2'd1;
	localparam logic [1:0] PH_CAND  = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PREP = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	// Multiply operations of the cosine test, in issue order.
	typedef enum logic [9:0] {
		OP_DOT_X = 10'b0000000001,
		OP_DOT_Y = 10'b0000000010,
		OP_DSQ   = 10'b0000000100,
		OP_N1_X  = 10'b0000001000,
		OP_N1_Y  = 10'b0000010000,
		OP_N2_X  = 10'b0000100000,
		OP_N2_Y  = 10'b0001000000,
		OP_N12   = 10'b0010000000,
		OP_THR_A = 10'b0100000000,
		OP_THR_B = 10'b1000000000
	} op_t;

endpackage

`default_nettype wire

// ===== sv/collinear_vertex_culler_unit.sv =====
// ---------------------------------------------------------------------------
// collinear_vertex_culler_unit: drops nearly collinear polygon vertices
// Vertices stream in as Q16.16 x,y pairs; a candidate is dropped when the
// cosine between the next segment and the reference direction exceeds the
// programmed threshold. The test is exact and uses no square root.
// ---------------------------------------------------------------------------
`default_nettype none

// The unit takes one vertex at a time and is not ready again until every kept
// vertex caused by it has been handed to the output register. The first and
// second vertex of a polygon and a vertex with a zero-length segment skip the
// multiplies. A full cosine test runs ten multiplies through one shared
// multiply-accumulate unit that consumes 8 multiplier bits per cycle; each
// multiply has a load step, one step per significant multiplier byte and a
// finish step. When the sign of the dot product already settles the test only
// the first two multiplies run. A wait for the sink holds the unit in its emit
// state.
// The output register lets one kept vertex wait for the sink while the next
// vertex is processed.
module collinear_vertex_culler_unit #(
	parameter int COORD_BITS = cvc_pkg::CVC_COORD_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input vertices
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [cvc_pkg::CVC_DATA_W-1:0] s_tdata,   // px [31:0], py [63:32]
	input  wire logic                           s_tlast,   // last_in
	// Kept vertices
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [cvc_pkg::CVC_DATA_W-1:0]      m_tdata,   // qx [31:0], qy [63:32]
	output logic                                m_tlast,   // last_out
	// Configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [cvc_pkg::CVC_PADDR_W-1:0] paddr,
	input  wire logic [cvc_pkg::CVC_PDATA_W-1:0] pwdata,
	output logic [cvc_pkg::CVC_PDATA_W-1:0]     prdata,
	output logic                                pready
);

	import cvc_pkg::*;

	localparam int CB   = COORD_BITS;
	localparam int DW   = CB + 1;         // segment component
	localparam int PW   = 2 * DW + 1;     // widest multiplier operand
	localparam int NW   = 2 * DW + 1;     // squared length
	localparam int DSQW = 2 * PW;         // squared dot product
	localparam int RW   = DSQW + 32;      // compare width
	localparam int AW   = RW + 1;         // accumulator, two's complement

	function automatic logic [DW-1:0] mag_dw(input logic [DW-1:0] v);
		return v[DW-1] ? DW'(~v + 1'b1) : v;
	endfunction

	// Registers
	state_t                 state_q;
	op_t                    op_q;
	logic [1:0]             phase_q;
	logic [CVC_THR_W-1:0]   thr_q;
	logic                   emit_held_q;
	logic                   emit_new_q;
	logic                   m_tvalid_q;

	logic [CB-1:0]          in_x_q, in_y_q;
	logic                   in_last_q;
	logic [CB-1:0]          held_x_q, held_y_q;
	logic [DW-1:0]          ref_x_q, ref_y_q;
	logic [AW-1:0]          acc_q;
	logic [AW-1:0]          mcand_q;
	logic [PW-1:0]          mplier_q;
	logic                   sub_q;
	logic [DSQW-1:0]        dsq_q;
	logic [NW-1:0]          n1_q;
	logic [CVC_FIELD_W-1:0] qx_q, qy_q;
	logic                   qlast_q;

	// Combinational
	logic [CB-1:0]          s_x_c, s_y_c;
	logic [CB-1:0]          out_x_c, out_y_c;
	logic [CVC_FIELD_W-1:0] out_x32_c, out_y32_c;
	logic [DW-1:0]          dx_c, dy_c;
	logic [DW-1:0]          ax_c, ay_c, arx_c, ary_c;
	logic [AW-1:0]          acc_mag_c;
	logic [CVC_THR_W-1:0]   thr_mag_c;
	logic                   thr_neg_c;
	logic                   zero_len_c;
	logic                   mul_done_c;
	logic                   dot_pos_c, dot_neg_c;
	logic [RW-1:0]          lhs_c, rhs_c;
	logic                   decide_c, near_c;
	logic                   ref_load_c, held_load_c;
	logic                   out_free_c, out_load_c;
	logic                   cfg_wr_c;
	logic [AW-1:0]          ld_mcand_c;
	logic [PW-1:0]          ld_mplier_c;
	logic                   ld_sub_c, ld_keep_c;
	logic [AW+MUL_DIGIT-1:0] prod_c;

	// Coordinate conversion: the low COORD_BITS bits carry the coordinate.
	if (CB <= CVC_FIELD_W) begin : g_in_narrow
		assign s_x_c = s_tdata[CB-1:0];
		assign s_y_c = s_tdata[CVC_FIELD_W+CB-1:CVC_FIELD_W];
	end else begin : g_in_wide
		assign s_x_c = {{(CB-CVC_FIELD_W){1'b0}}, s_tdata[CVC_FIELD_W-1:0]};
		assign s_y_c = {{(CB-CVC_FIELD_W){1'b0}}, s_tdata[2*CVC_FIELD_W-1:CVC_FIELD_W]};
	end

	assign out_x_c = emit_held_q ? held_x_q : in_x_q;
	assign out_y_c = emit_held_q ? held_y_q : in_y_q;

	if (CB >= CVC_FIELD_W) begin : g_out_wide
		assign out_x32_c = out_x_c[CVC_FIELD_W-1:0];
		assign out_y32_c = out_y_c[CVC_FIELD_W-1:0];
	end else begin : g_out_narrow
		assign out_x32_c = {{(CVC_FIELD_W-CB){1'b0}}, out_x_c};
		assign out_y32_c = {{(CVC_FIELD_W-CB){1'b0}}, out_y_c};
	end

	// Segment from the held vertex to the new one.
	assign dx_c  = {in_x_q[CB-1], in_x_q} - {held_x_q[CB-1], held_x_q};
	assign dy_c  = {in_y_q[CB-1], in_y_q} - {held_y_q[CB-1], held_y_q};
	assign ax_c  = mag_dw(dx_c);
	assign ay_c  = mag_dw(dy_c);
	assign arx_c = mag_dw(ref_x_q);
	assign ary_c = mag_dw(ref_y_q);

	assign zero_len_c = ((dx_c == '0) && (dy_c == '0)) || ((ref_x_q == '0) && (ref_y_q == '0));

	assign acc_mag_c = acc_q[AW-1] ? AW'(~acc_q + 1'b1) : acc_q;
	assign thr_neg_c = thr_q[CVC_THR_W-1];
	assign thr_mag_c = thr_neg_c ? CVC_THR_W'(~thr_q + 1'b1) : thr_q;

	assign mul_done_c = (mplier_q == '0);
	assign dot_neg_c  = acc_q[AW-1];
	assign dot_pos_c  = !acc_q[AW-1] && (acc_q != '0);

	assign lhs_c = {{(RW-DSQW-CVC_LHS_SHIFT){1'b0}}, dsq_q, {CVC_LHS_SHIFT{1'b0}}};
	assign rhs_c = acc_q[RW-1:0];

	// One multiplier byte per step.
	assign prod_c = mcand_q * mplier_q[MUL_DIGIT-1:0];

	// Operand selection for the next multiply.
	always_comb begin
		ld_mcand_c  = '0;
		ld_mplier_c = '0;
		ld_sub_c    = 1'b0;
		ld_keep_c   = 1'b0;
		case (op_q)
			OP_DOT_X: begin
				ld_mcand_c  = {{(AW-DW){1'b0}}, ax_c};
				ld_mplier_c = {{(PW-DW){1'b0}}, arx_c};
				ld_sub_c    = dx_c[DW-1] ^ ref_x_q[DW-1];
			end
			OP_DOT_Y: begin
				ld_mcand_c  = {{(AW-DW){1'b0}}, ay_c};
				ld_mplier_c = {{(PW-DW){1'b0}}, ary_c};
				ld_sub_c    = dy_c[DW-1] ^ ref_y_q[DW-1];
				ld_keep_c   = 1'b1;
			end
			OP_DSQ: begin
				ld_mcand_c  = {{(AW-PW){1'b0}}, acc_mag_c[PW-1:0]};
				ld_mplier_c = acc_mag_c[PW-1:0];
			end
			OP_N1_X: begin
				ld_mcand_c  = {{(AW-DW){1'b0}}, ax_c};
				ld_mplier_c = {{(PW-DW){1'b0}}, ax_c};
			end
			OP_N1_Y: begin
				ld_mcand_c  = {{(AW-DW){1'b0}}, ay_c};
				ld_mplier_c = {{(PW-DW){1'b0}}, ay_c};
				ld_keep_c   = 1'b1;
			end
			OP_N2_X: begin
				ld_mcand_c  = {{(AW-DW){1'b0}}, arx_c};
				ld_mplier_c = {{(PW-DW){1'b0}}, arx_c};
			end
			OP_N2_Y: begin
				ld_mcand_c  = {{(AW-DW){1'b0}}, ary_c};
				ld_mplier_c = {{(PW-DW){1'b0}}, ary_c};
				ld_keep_c   = 1'b1;
			end
			OP_N12: begin
				ld_mcand_c  = {{(AW-NW){1'b0}}, n1_q};
				ld_mplier_c = acc_q[PW-1:0];
			end
			OP_THR_A, OP_THR_B: begin
				ld_mcand_c  = acc_q;
				ld_mplier_c = {{(PW-CVC_THR_W){1'b0}}, thr_mag_c};
			end
			default: begin
				ld_mcand_c  = '0;
				ld_mplier_c = '0;
			end
		endcase
	end

	// Keep-or-drop decision for the held candidate.
	always_comb begin
		decide_c = 1'b0;
		near_c   = 1'b0;
		if (state_q == ST_PREP && phase_q == PH_CAND && zero_len_c) begin
			decide_c = 1'b1;
		end
		if (state_q == ST_MUL && mul_done_c) begin
			// The sign of the dot product alone settles many cases.
			if (op_q == OP_DOT_Y && (thr_neg_c ? !dot_neg_c : !dot_pos_c)) begin
				decide_c = 1'b1;
				near_c   = thr_neg_c;
			end
			if (op_q == OP_THR_B) begin
				decide_c = 1'b1;
				near_c   = thr_neg_c ? (lhs_c < rhs_c) : (lhs_c > rhs_c);
			end
		end
	end

	assign ref_load_c  = (state_q == ST_PREP && phase_q == PH_FIRST) || (decide_c && !near_c);
	assign held_load_c = (state_q == ST_EMIT) && !emit_held_q && !emit_new_q;
	assign out_free_c  = !m_tvalid_q || m_tready;
	assign out_load_c  = (state_q == ST_EMIT) && out_free_c && (emit_held_q || emit_new_q);
	assign cfg_wr_c    = psel && penable && pwrite && pready;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_DOT_X;
			phase_q     <= PH_NONE;
			thr_q       <= CVC_THR_RESET;
			emit_held_q <= 1'b0;
			emit_new_q  <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_wr_c && paddr[CVC_PADDR_W-1] == CFG_IDX_COS_THR) begin
				thr_q <= pwdata[CVC_THR_W-1:0];
			end

			if (out_load_c) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (phase_q == PH_CAND) begin
						if (!decide_c) begin
							op_q    <= OP_DOT_X;
							state_q <= ST_LOAD;
						end
					end else if (phase_q == PH_FIRST) begin
						phase_q    <= in_last_q ? PH_NONE : PH_CAND;
						emit_new_q <= in_last_q;
						state_q    <= ST_EMIT;
					end else begin
						// No vertex seen yet (the unused phase code acts the same).
						phase_q    <= in_last_q ? PH_NONE : PH_FIRST;
						emit_new_q <= 1'b1;
						state_q    <= ST_EMIT;
					end
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_done_c && !decide_c) begin
						state_q <= ST_LOAD;
						case (op_q)
							OP_DOT_X: op_q <= OP_DOT_Y;
							OP_DOT_Y: op_q <= OP_DSQ;
							OP_DSQ:   op_q <= OP_N1_X;
							OP_N1_X:  op_q <= OP_N1_Y;
							OP_N1_Y:  op_q <= OP_N2_X;
							OP_N2_X:  op_q <= OP_N2_Y;
							OP_N2_Y:  op_q <= OP_N12;
							OP_N12:   op_q <= OP_THR_A;
							OP_THR_A: op_q <= OP_THR_B;
							default:  op_q <= OP_DOT_X;
						endcase
					end
				end
				ST_EMIT: begin
					if (!emit_held_q && !emit_new_q) begin
						state_q <= ST_IDLE;
					end else if (out_free_c) begin
						if (emit_held_q) begin
							emit_held_q <= 1'b0;
						end else begin
							emit_new_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (decide_c) begin
				emit_held_q <= !near_c;
				emit_new_q  <= in_last_q;
				phase_q     <= in_last_q ? PH_NONE : PH_CAND;
				state_q     <= ST_EMIT;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			in_x_q    <= s_x_c;
			in_y_q    <= s_y_c;
			in_last_q <= s_tlast;
		end
		if (ref_load_c) begin
			ref_x_q <= dx_c;
			ref_y_q <= dy_c;
		end
		if (held_load_c) begin
			held_x_q <= in_x_q;
			held_y_q <= in_y_q;
		end

		if (state_q == ST_LOAD) begin
			acc_q    <= ld_keep_c ? acc_q : '0;
			mcand_q  <= ld_mcand_c;
			mplier_q <= ld_mplier_c;
			sub_q    <= ld_sub_c;
		end else if (state_q == ST_MUL && !mul_done_c) begin
			acc_q    <= sub_q ? acc_q - prod_c[AW-1:0] : acc_q + prod_c[AW-1:0];
			mcand_q  <= mcand_q << MUL_DIGIT;
			mplier_q <= mplier_q >> MUL_DIGIT;
		end

		if (state_q == ST_MUL && mul_done_c && op_q == OP_DSQ) begin
			dsq_q <= acc_q[DSQW-1:0];
		end
		if (state_q == ST_MUL && mul_done_c && op_q == OP_N1_Y) begin
			n1_q <= acc_q[NW-1:0];
		end

		if (out_load_c) begin
			qx_q    <= out_x32_c;
			qy_q    <= out_y32_c;
			qlast_q <= emit_held_q ? 1'b0 : in_last_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {qy_q, qx_q};
	assign m_tlast  = qlast_q;
	assign pready   = 1'b1;
	assign prdata   = (paddr[CVC_PADDR_W-1] == CFG_IDX_COS_THR) ?
	                  {{(CVC_PDATA_W-CVC_THR_W){thr_q[CVC_THR_W-1]}}, thr_q} : '0;

	// Nothing may still be owed to the output once the unit takes a new item.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!emit_held_q && !emit_new_q))
		else $error("pending kept vertex while idle");

	// A held candidate is only owed while a candidate exists or the polygon ends.
	a_held_phase: assert property (@(posedge clk) disable iff (!arst_n)
		emit_held_q |-> ((phase_q == PH_CAND) || in_last_q))
		else $error("candidate emitted outside the candidate phase");

	// The scaled threshold product can never come out negative.
	a_rhs_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && op_q == OP_THR_B && mul_done_c) |-> !acc_q[AW-1])
		else $error("threshold product negative");

	// Output items are only produced from the emit state.
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_EMIT))
		else $error("output item outside emit state");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking test of collinear_vertex_culler_unit
// Streams polygons through the culler and compares every kept vertex with
// an internal prediction. The prediction runs the exact cosine test on wide
// integers. The cosine threshold is reprogrammed between phases, both stream
// sides idle at random, and the sink holds off for a long stretch in one phase.
// ---------------------------------------------------------------------------
module testbench;
	import cvc_pkg::*;

	localparam int CW           = CVC_COORD_BITS;
	localparam int WIDE         = 256;
	localparam int PADDR_W      = CVC_PADDR_W;
	localparam int PDATA_W      = CVC_PDATA_W;
	localparam int NUM_PHASES   = 9;
	localparam int RANDOM_ITEMS = 1550;
	localparam int PHASE_ITEMS  = RANDOM_ITEMS / NUM_PHASES;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_LIMIT = 10;
	localparam logic [PADDR_W-1:0] COS_THR_ADDR = PADDR_W'(4 * int'(CFG_IDX_COS_THR));

	typedef struct packed {
		logic [CW-1:0] qx;
		logic [CW-1:0] qy;
		logic          last;
	} kept_vertex_t;

	class vertex_scoreboard;
		logic signed [CVC_THR_W-1:0] cos_thr;
		logic [1:0]                  phase;
		logic [CW-1:0]               held_x;
		logic [CW-1:0]               held_y;
		logic signed [CW:0]          ref_dx;
		logic signed [CW:0]          ref_dy;
		kept_vertex_t                kept_q[$];
		int                          errors;

		function new();
			cos_thr = CVC_THR_RESET;
			phase = PH_NONE;
			held_x = '0;
			held_y = '0;
			ref_dx = '0;
			ref_dy = '0;
			errors = 0;
		endfunction

		function void set_threshold(logic signed [CVC_THR_W-1:0] thr);
			cos_thr = thr;
		endfunction

		function int pending();
			return kept_q.size();
		endfunction

		function bit [WIDE-1:0] magnitude(longint v);
			bit [WIDE-1:0] w;
			if (v < 0)
				v = -v;
			w = WIDE'(v);
			return w;
		endfunction

		// Exact test of cos(seg, ref) > cos_thr / 2^15 without a square root.
		function bit near_collinear(logic signed [CW:0] dx, logic signed [CW:0] dy,
				logic signed [CW:0] rx, logic signed [CW:0] ry);
			bit [WIDE-1:0] ax, ay, arx, ary, pos, neg, p, dot, lhs, rhs, tm;
			if ((dx == 0 && dy == 0) || (rx == 0 && ry == 0))
				return 1'b0;
			ax = magnitude(dx);
			ay = magnitude(dy);
			arx = magnitude(rx);
			ary = magnitude(ry);
			tm = magnitude(cos_thr);
			pos = '0;
			neg = '0;
			p = ax * arx;
			if (dx[CW] != rx[CW])
				neg = neg + p;
			else
				pos = pos + p;
			p = ay * ary;
			if (dy[CW] != ry[CW])
				neg = neg + p;
			else
				pos = pos + p;
			dot = (pos >= neg) ? pos - neg : neg - pos;
			lhs = (dot * dot) << CVC_LHS_SHIFT;
			rhs = (ax * ax + ay * ay) * (arx * arx + ary * ary) * (tm * tm);
			if (!cos_thr[CVC_THR_W-1])
				return pos > neg && lhs > rhs;
			if (pos >= neg)
				return 1'b1;
			return lhs < rhs;
		endfunction

		function void add_kept(logic [CW-1:0] x, logic [CW-1:0] y, logic last);
			kept_vertex_t v;
			v.qx = x;
			v.qy = y;
			v.last = last;
			kept_q.insert(kept_q.size(), v);
		endfunction

		function void note_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic last);
			logic signed [CW:0] dx, dy;
			dx = $signed({x[CW-1], x}) - $signed({held_x[CW-1], held_x});
			dy = $signed({y[CW-1], y}) - $signed({held_y[CW-1], held_y});
			case (phase)
			PH_FIRST: begin
				ref_dx = dx;
				ref_dy = dy;
				phase = PH_CAND;
			end
			PH_CAND: begin
				if (!near_collinear(dx, dy, ref_dx, ref_dy)) begin
					add_kept(held_x, held_y, 1'b0);
					ref_dx = dx;
					ref_dy = dy;
				end
			end
			default: begin
				// Start of a polygon: the first vertex always goes out.
				add_kept(x, y, last);
				held_x = x;
				held_y = y;
				phase = last ? PH_NONE : PH_FIRST;
				return;
			end
			endcase
			held_x = x;
			held_y = y;
			if (last) begin
				add_kept(x, y, 1'b1);
				phase = PH_NONE;
			end
		endfunction

		function void check_kept(logic [CW-1:0] qx, logic [CW-1:0] qy, logic last);
			kept_vertex_t want;
			if (kept_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected kept vertex x=%h y=%h last=%b", qx, qy, last);
				return;
			end
			want = kept_q.pop_front();
			if (want.qx !== qx || want.qy !== qy || want.last !== last) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("kept vertex mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
						want.qx, want.qy, want.last, qx, qy, last);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [CVC_DATA_W-1:0] s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [CVC_DATA_W-1:0] m_tdata;
	logic                m_tlast;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	vertex_scoreboard sb;
	int snd_idle_pct;
	int rcv_idle_pct;
	int items_sent;
	bit hold_req;

	collinear_vertex_culler_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("testbench failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_kept(m_tdata[CW-1:0], m_tdata[2*CW-1:CW], m_tlast);
	end

	// Sink side: random stalls, plus one long hold-off on request.
	initial begin : sink_drive
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	function automatic logic [CW-1:0] scaled_rand(int s);
		logic signed [CW-1:0] r;
		r = $urandom;
		return r >>> (CW - 1 - s);
	endfunction

	function automatic logic [CW-1:0] extreme_coord();
		case ($urandom_range(0, 4))
		0: return {1'b1, {(CW - 1){1'b0}}};
		1: return {1'b0, {(CW - 1){1'b1}}};
		2: return '0;
		3: return '1;
		default: return CW'(1);
		endcase
	endfunction

	// Returns right after the rising edge that accepted the item.
	task automatic send_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic last);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		s_tlast <= last;
		do begin
			@(posedge clk);
		end while (!s_tready);
		sb.note_vertex(x, y, last);
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		// The last vertex may still be under test without a kept vertex.
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(logic signed [CVC_THR_W-1:0] thr);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COS_THR_ADDR;
		pwdata <= {{(PDATA_W - CVC_THR_W){1'b0}}, thr};
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		sb.set_threshold(thr);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Most polygons are straight runs, right-angle turns, reversals or
	// repeated points; a few are raw random or extreme coordinates.
	task automatic send_polygon();
		int n, kind, s, jb;
		logic [CW-1:0] x, y, vx, vy, t;
		n = $urandom_range(1, 12);
		kind = $urandom_range(0, 9);
		s = $urandom_range(0, CW - 2);
		jb = (s > 3) ? $urandom_range(0, s - 3) : 0;
		x = $urandom;
		y = $urandom;
		vx = scaled_rand(s);
		vy = (kind == 5) ? '0 : scaled_rand(s);
		for (int j = 0; j < n; j++) begin
			if (kind == 7) begin
				x = $urandom;
				y = $urandom;
			end else if (kind == 8) begin
				x = extreme_coord();
				y = extreme_coord();
			end
			send_vertex(x, y, j == n - 1);
			case (kind)
			5: begin
				if ($urandom_range(0, 2) == 0) begin
					t = vx;
					vx = -vy;
					vy = t;
				end
			end
			9: begin
				vx = -vx;
				vy = -vy;
			end
			default: ;
			endcase
			if (kind != 6 || $urandom_range(0, 1)) begin
				x = x + vx;
				y = y + vy;
			end
			if (kind <= 4 && $urandom_range(0, 1)) begin
				x = x + scaled_rand(jb);
				y = y + scaled_rand(jb);
			end
		end
	endtask

	function automatic logic signed [CVC_THR_W-1:0] phase_threshold(int ph);
		case (ph)
		1: return 16'sd32767;
		2: return -16'sd32768;
		3: return 16'sd0;
		4: return -16'sd1;
		5: return CVC_THR_W'($urandom);
		6: return 16'sd1;
		7: return CVC_THR_W'(-$urandom_range(1, 32768));
		default: return CVC_THR_RESET;
		endcase
	endfunction

	initial begin : stimulus
		int start;
		bit paused;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_req = 1'b0;
		items_sent = 0;
		snd_idle_pct = 37;
		rcv_idle_pct = 68;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Single-vertex and two-vertex polygons at the coordinate extremes.
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		// Straight run: middle vertices are dropped.
		send_vertex(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_vertex(32'h0001_0000, 32'h0000_0000, 1'b0);
		send_vertex(32'h0002_0000, 32'h0000_0000, 1'b0);
		send_vertex(32'h0003_0000, 32'h0000_0000, 1'b1);
		// Repeated points give zero-length segments.
		send_vertex(32'h0000_0005, 32'h0000_0005, 1'b0);
		send_vertex(32'h0000_0005, 32'h0000_0005, 1'b0);
		send_vertex(32'h0000_0005, 32'h0000_0005, 1'b0);
		send_vertex(32'h0000_0009, 32'h0000_0001, 1'b1);
		// Right angle, reversal, then a straight step.
		send_vertex(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_vertex(32'h0000_000A, 32'h0000_0000, 1'b0);
		send_vertex(32'h0000_000A, 32'h0000_000A, 1'b0);
		send_vertex(32'h0000_000A, 32'h0000_0000, 1'b0);
		send_vertex(32'h0000_000A, 32'hFFFF_FFF6, 1'b1);
		// Full-range segments.
		send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);

		paused = 1'b0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph / 3)
			0: begin
				snd_idle_pct = 37;
				rcv_idle_pct = 68;
			end
			1: begin
				snd_idle_pct = 68;
				rcv_idle_pct = 37;
			end
			default: begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			endcase
			if (ph > 0) begin
				drain_results();
				write_threshold(phase_threshold(ph));
			end
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				send_polygon();
				// Long sink stall while vertices keep coming.
				if (ph == 1 && items_sent - start >= 40 && items_sent - start < 52)
					hold_req = 1'b1;
				// Source waits for every kept vertex before going on.
				if (ph == 5 && !paused && items_sent - start >= 80) begin
					paused = 1'b1;
					drain_results();
				end
			end
		end

		drain_results();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/cvc_pkg.sv
sv/collinear_vertex_culler_unit.sv
test/testbench.sv
